// File: hw/rtl/dkbf_pkg.sv
// Shared constants, types and codes of the k-mer bucket filter.
`timescale 1ns / 1ps

package dkbf_pkg;

  // Window geometry
  localparam int MAX_KMER_LEN = 11;
  localparam int KMER_W       = 2 * MAX_KMER_LEN;
  localparam int EFF_W        = $clog2(MAX_KMER_LEN + 1);

  // Bucketing and histogram store
  localparam int BUCKET_WIDTH = 1024;
  localparam int BUCKET_SHIFT = $clog2(BUCKET_WIDTH);
  localparam int HIST_BINS    = 4096;
  localparam int HIST_AW      = $clog2(HIST_BINS);

  // Field widths fixed by the interface
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 4;
  localparam int SEL_W  = 12;
  localparam int BIN_W  = 12;
  localparam int POS_W  = 32;
  localparam int CNT_W  = 32;

  // Configuration port
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam logic [LEN_W-1:0] KMER_LENGTH_RST = 4'd8;
  localparam logic [SEL_W-1:0] BUCKET_SELECT_RST = '0;

  // Register indexes (address bit above the word offset)
  localparam logic REG_KMER_LENGTH   = 1'b0;
  localparam logic REG_BUCKET_SELECT = 1'b1;

  // Word modes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Base characters and their 2-bit codes
  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_N = 8'h4E;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  localparam logic [1:0] CODE_A = 2'h0;
  localparam logic [1:0] CODE_C = 2'h1;
  localparam logic [1:0] CODE_G = 2'h2;
  localparam logic [1:0] CODE_T = 2'h3;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } ctrl_state_e;

  typedef struct packed {
    logic [LEN_W-1:0] kmer_length;
    logic [SEL_W-1:0] bucket_select;
  } cfg_t;

  // Result of the window stage plus the histogram access it needs
  typedef struct packed {
    logic               is_read;
    logic               hist_inc;
    logic               hist_ok;
    logic [HIST_AW-1:0] hist_addr;
    logic               window_full;
    logic [KMER_W-1:0]  kmer_value;
    logic [POS_W-1:0]   window_start;
    logic               in_bucket;
    logic               bad_base;
  } win_res_t;

endpackage

// File: hw/rtl/dkbf_in_if.sv
// Input channel: one base or histogram read request per word.
`timescale 1ns / 1ps

interface dkbf_in_if import dkbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAR_W-1:0] base_char;
  logic              new_sequence;
  logic [BIN_W-1:0]  bin_index;

  modport source (output valid, mode, base_char, new_sequence, bin_index, input ready);
  modport sink   (input valid, mode, base_char, new_sequence, bin_index, output ready);
endinterface

// File: hw/rtl/dkbf_out_if.sv
// Output channel: one result word per accepted input word.
`timescale 1ns / 1ps

interface dkbf_out_if import dkbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              window_full;
  logic [KMER_W-1:0] kmer_value;
  logic [POS_W-1:0]  window_start;
  logic              in_bucket;
  logic              bad_base;
  logic [CNT_W-1:0]  bin_count;

  modport source (output valid, window_full, kmer_value, window_start, in_bucket, bad_base,
                  bin_count, input ready);
  modport sink   (input valid, window_full, kmer_value, window_start, in_bucket, bad_base,
                  bin_count, output ready);
endinterface

// File: hw/rtl/dkbf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module dkbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/dkbf_window.sv
// Rolling k-mer window: base encoding, window state and bucket decision.
`timescale 1ns / 1ps

module dkbf_window import dkbf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              accept_i,
  input  logic              mode_i,
  input  logic [CHAR_W-1:0] base_char_i,
  input  logic              new_sequence_i,
  input  logic [BIN_W-1:0]  bin_index_i,
  output win_res_t          res_o
);

  logic [KMER_W-1:0] kmer_shift_q, kmer_shift_d;
  logic [EFF_W-1:0]  fill_count_q, fill_count_d;
  logic [POS_W-1:0]  base_position_q, base_position_d;
  logic              error_flag_q, error_flag_d;

  logic [EFF_W-1:0]  eff_len;
  logic [KMER_W-1:0] kmer_b;
  logic [EFF_W-1:0]  fill_b;
  logic [POS_W-1:0]  pos_b;
  logic              err_b;
  logic [POS_W-1:0]  pos_next;
  logic [POS_W-1:0]  len_m1;
  logic [POS_W-1:0]  start;
  logic [1:0]        code;
  logic              code_ok;
  logic [KMER_W-1:0] mask;
  logic [KMER_W-1:0] shifted;
  logic [EFF_W-1:0]  fill_next;
  logic              full;
  logic [31:0]       bucket;
  logic              bucket_ok;

  // Clamp the configured length to the supported range
  always_comb begin
    if (cfg_i.kmer_length == '0) begin
      eff_len = EFF_W'(1);
    end else if (32'(cfg_i.kmer_length) > MAX_KMER_LEN) begin
      eff_len = EFF_W'(MAX_KMER_LEN);
    end else begin
      eff_len = EFF_W'(cfg_i.kmer_length);
    end
  end

  // Encode the base character
  always_comb begin
    code_ok = 1'b1;
    case (base_char_i)
      CHAR_A:  code = CODE_A;
      CHAR_N:  code = CODE_A;
      CHAR_C:  code = CODE_C;
      CHAR_G:  code = CODE_G;
      CHAR_T:  code = CODE_T;
      default: begin
        code    = CODE_A;
        code_ok = 1'b0;
      end
    endcase
  end

  // Roll the window forward by one base
  always_comb begin
    kmer_b = new_sequence_i ? '0 : kmer_shift_q;
    fill_b = new_sequence_i ? '0 : fill_count_q;
    pos_b  = new_sequence_i ? '0 : base_position_q;
    err_b  = new_sequence_i ? 1'b0 : error_flag_q;

    pos_next = (pos_b == '1) ? pos_b : pos_b + POS_W'(1);

    for (int i = 0; i < KMER_W; i++) begin
      mask[i] = (i < 2 * int'(eff_len));
    end
    shifted   = KMER_W'({kmer_b, code}) & mask;
    fill_next = (fill_b < eff_len) ? fill_b + EFF_W'(1) : eff_len;
    full      = code_ok && (fill_next >= eff_len);

    len_m1 = POS_W'(eff_len) - POS_W'(1);
    start  = (pos_b >= len_m1) ? pos_b - len_m1 : '0;

    bucket    = 32'(shifted) >> BUCKET_SHIFT;
    bucket_ok = bucket < 32'(HIST_BINS);
  end

  // Build the result word
  always_comb begin
    res_o = '0;
    if (mode_i == MODE_READ) begin
      res_o.is_read   = 1'b1;
      res_o.hist_ok   = 32'(bin_index_i) < 32'(HIST_BINS);
      res_o.hist_addr = HIST_AW'(bin_index_i);
      res_o.bad_base  = error_flag_q;
    end else begin
      res_o.hist_addr   = HIST_AW'(bucket);
      res_o.hist_ok     = bucket_ok;
      res_o.hist_inc    = full && bucket_ok && (cfg_i.bucket_select == '0);
      res_o.window_full = full;
      res_o.kmer_value  = full ? shifted : '0;
      res_o.window_start = full ? start : '0;
      res_o.in_bucket   = full && (bucket == 32'(cfg_i.bucket_select));
      res_o.bad_base    = code_ok ? err_b : 1'b1;
    end
  end

  // Next window state; read words leave it alone
  always_comb begin
    kmer_shift_d    = kmer_shift_q;
    fill_count_d    = fill_count_q;
    base_position_d = base_position_q;
    error_flag_d    = error_flag_q;
    if (accept_i && (mode_i == MODE_PUSH)) begin
      base_position_d = pos_next;
      if (code_ok) begin
        kmer_shift_d = shifted;
        fill_count_d = fill_next;
        error_flag_d = err_b;
      end else begin
        kmer_shift_d = '0;
        fill_count_d = '0;
        error_flag_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_shift_q    <= '0;
      fill_count_q    <= '0;
      base_position_q <= '0;
      error_flag_q    <= 1'b0;
    end else begin
      kmer_shift_q    <= kmer_shift_d;
      fill_count_q    <= fill_count_d;
      base_position_q <= base_position_d;
      error_flag_q    <= error_flag_d;
    end
  end

endmodule

// File: hw/rtl/dna_kmer_bucket_filter.sv
// Top level of the DNA k-mer bucket filter with its bucket histogram.
// Each accepted word passes stage one and then the output register.
// Throughput: one word per cycle unless the output stalls; the histogram update
// reads the RAM and writes back, with the last write forwarded to the next read.
// Reset: window state and config clear at once; a clearing pass then zeroes all
// 4096 histogram bins, one per cycle, with input ready low (config writes still taken).
`timescale 1ns / 1ps

module dna_kmer_bucket_filter import dkbf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  dkbf_in_if.sink           in_i,
  dkbf_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg_q, cfg_d;

  ctrl_state_e        state_q, state_d;
  logic [HIST_AW-1:0] clr_addr_q, clr_addr_d;
  logic               clearing;

  win_res_t res_s0;
  logic     accept_s0;

  win_res_t s1_res_q;
  logic     s1_valid_q;
  logic     s1_adv;

  logic               fwd_valid_q;
  logic [HIST_AW-1:0] fwd_addr_q;
  logic [CNT_W-1:0]   fwd_data_q;

  logic [CNT_W-1:0]   ram_rdata;
  logic [CNT_W-1:0]   cur_count;
  logic [CNT_W-1:0]   inc_count;
  logic               ram_we;
  logic [HIST_AW-1:0] ram_waddr;
  logic [CNT_W-1:0]   ram_wdata;
  logic               hist_wr;

  logic              out_valid_q;
  logic              out_window_full_q;
  logic [KMER_W-1:0] out_kmer_value_q;
  logic [POS_W-1:0]  out_window_start_q;
  logic              out_in_bucket_q;
  logic              out_bad_base_q;
  logic [CNT_W-1:0]  out_bin_count_q;

  // Configuration registers
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (paddr[APB_AW-1])
        REG_KMER_LENGTH:   cfg_d.kmer_length   = pwdata[LEN_W-1:0];
        REG_BUCKET_SELECT: cfg_d.bucket_select = pwdata[SEL_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[APB_AW-1])
      REG_KMER_LENGTH:   prdata = APB_DW'(cfg_q.kmer_length);
      REG_BUCKET_SELECT: prdata = APB_DW'(cfg_q.bucket_select);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kmer_length   <= KMER_LENGTH_RST;
      cfg_q.bucket_select <= BUCKET_SELECT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Clear the histogram after reset, then run
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    clearing   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clearing   = 1'b1;
        clr_addr_d = clr_addr_q + HIST_AW'(1);
        if (clr_addr_q == HIST_AW'(HIST_BINS - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        clearing = 1'b0;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Handshake: once cleared, take a word whenever stage one is free or moving on
  assign s1_adv    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !clearing && (!s1_valid_q || s1_adv);
  assign accept_s0 = in_i.valid && in_i.ready;

  dkbf_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept_s0),
    .mode_i         (in_i.mode),
    .base_char_i    (in_i.base_char),
    .new_sequence_i (in_i.new_sequence),
    .bin_index_i    (in_i.bin_index),
    .res_o          (res_s0)
  );

  // Stage one: the word waits here for its histogram read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept_s0) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_s0) begin
      s1_res_q <= res_s0;
    end
  end

  // Forward the last write-back when the read raced it
  assign cur_count = (fwd_valid_q && (fwd_addr_q == s1_res_q.hist_addr)) ? fwd_data_q
                                                                         : ram_rdata;
  assign inc_count = (cur_count == '1) ? cur_count : cur_count + CNT_W'(1);
  assign hist_wr   = s1_adv && s1_res_q.hist_inc;

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = hist_wr;
      ram_waddr = s1_res_q.hist_addr;
      ram_wdata = inc_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (hist_wr) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_wr) begin
      fwd_addr_q <= s1_res_q.hist_addr;
      fwd_data_q <= inc_count;
    end
  end

  dkbf_ram #(
    .WIDTH (CNT_W),
    .DEPTH (HIST_BINS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept_s0),
    .raddr_i (res_s0.hist_addr),
    .rdata_o (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_window_full_q  <= s1_res_q.window_full;
      out_kmer_value_q   <= s1_res_q.kmer_value;
      out_window_start_q <= s1_res_q.window_start;
      out_in_bucket_q    <= s1_res_q.in_bucket;
      out_bad_base_q     <= s1_res_q.bad_base;
      out_bin_count_q    <= (s1_res_q.is_read && s1_res_q.hist_ok) ? cur_count : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.window_full  = out_window_full_q;
  assign out_o.kmer_value   = out_kmer_value_q;
  assign out_o.window_start = out_window_start_q;
  assign out_o.in_bucket    = out_in_bucket_q;
  assign out_o.bad_base     = out_bad_base_q;
  assign out_o.bin_count    = out_bin_count_q;

endmodule

// File: hw/rtl/dkbf_checker.sv
// Port-level checks of the k-mer bucket filter, bound to its top level.
`timescale 1ns / 1ps

module dkbf_checker import dkbf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              out_window_full_i,
  input logic [KMER_W-1:0] out_kmer_value_i,
  input logic [POS_W-1:0]  out_window_start_i,
  input logic [CNT_W-1:0]  out_bin_count_i
);

  // Hold a result word until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped before it was taken");

  // Keep a stalled result word stable
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_window_full_i) && $stable(out_kmer_value_i)
      && $stable(out_window_start_i) && $stable(out_bin_count_i))
    else $error("stalled result word changed");

  // An accepted word shows up after stage one when the output drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 (!out_valid_i || out_ready_i) |=> out_valid_i)
    else $error("accepted word produced no result in time");

  // Refuse input right after reset while the histogram is cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !in_ready_i)
    else $error("input accepted before the histogram was cleared");

endmodule

bind dna_kmer_bucket_filter dkbf_checker u_dkbf_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_window_full_i  (out_o.window_full),
  .out_kmer_value_i   (out_o.kmer_value),
  .out_window_start_i (out_o.window_start),
  .out_bin_count_i    (out_o.bin_count)
);

// File: test/tb_dna_kmer_bucket_filter.sv
// Self-checking testbench for the DNA k-mer bucket filter and its histogram.
`timescale 1ns / 1ps

module tb_dna_kmer_bucket_filter;
  import dkbf_pkg::*;

  localparam int          QUIET_LIMIT = 20000;  // covers the clearing pass after reset
  localparam int          HOLD_CYCLES = 64;
  localparam int          MAX_REPORTS = 10;
  localparam logic [CHAR_W-1:0] LOWER_A = 8'h61;  // lowercase letters are not bases

  typedef struct packed {
    logic              mode;
    logic [CHAR_W-1:0] base_char;
    logic              new_sequence;
    logic [BIN_W-1:0]  bin_index;
  } base_word_t;

  typedef struct packed {
    logic              window_full;
    logic [KMER_W-1:0] kmer_value;
    logic [POS_W-1:0]  window_start;
    logic              in_bucket;
    logic              bad_base;
    logic [CNT_W-1:0]  bin_count;
  } kmer_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  dkbf_in_if  in_ch ();
  dkbf_out_if out_ch ();

  dna_kmer_bucket_filter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted block state and configuration
  logic [LEN_W-1:0]  cfg_len = KMER_LENGTH_RST;
  logic [SEL_W-1:0]  cfg_sel = BUCKET_SELECT_RST;
  logic [KMER_W-1:0] win_shift = '0;
  int unsigned       win_fill = 0;
  logic [POS_W-1:0]  next_pos = '0;
  logic              seq_error = 1'b0;
  logic [CNT_W-1:0]  bin_counts [HIST_BINS];

  kmer_res_t   kmer_results_q [$];
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  bit          hold_req = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Roll one word through the predicted window and histogram
  function automatic kmer_res_t roll_kmer(input base_word_t w);
    kmer_res_t        r;
    logic [1:0]       code;
    logic             char_ok;
    int unsigned      k;
    logic [POS_W-1:0] pos;
    logic [63:0]      mask;
    logic [63:0]      lo;
    logic [63:0]      bucket;
    r = '0;
    if (w.mode == MODE_READ) begin
      r.bad_base  = seq_error;
      r.bin_count = (int'(w.bin_index) < HIST_BINS) ? bin_counts[w.bin_index] : '0;
      return r;
    end
    if (w.new_sequence) begin
      win_shift = '0;
      win_fill  = 0;
      next_pos  = '0;
      seq_error = 1'b0;
    end
    k = (cfg_len == 0) ? 1 : (cfg_len > MAX_KMER_LEN) ? MAX_KMER_LEN : cfg_len;
    pos = next_pos;
    if (next_pos != '1) next_pos = next_pos + 1;
    char_ok = 1'b1;
    code    = CODE_A;
    case (w.base_char)
      CHAR_A, CHAR_N: code = CODE_A;
      CHAR_C:         code = CODE_C;
      CHAR_G:         code = CODE_G;
      CHAR_T:         code = CODE_T;
      default:        char_ok = 1'b0;
    endcase
    // Drop the window on a bad character; the position still advances
    if (!char_ok) begin
      seq_error = 1'b1;
      win_shift = '0;
      win_fill  = 0;
      r.bad_base = 1'b1;
      return r;
    end
    mask = (64'd1 << (2 * k)) - 64'd1;
    win_shift = KMER_W'(((64'(win_shift) << 2) | 64'(code)) & mask);
    if (win_fill < k) win_fill = win_fill + 1;
    else win_fill = k;
    if (win_fill >= k) begin
      r.window_full  = 1'b1;
      r.kmer_value   = win_shift;
      r.window_start = (pos >= k - 1) ? pos - (k - 1) : '0;
      lo = 64'(cfg_sel) * BUCKET_WIDTH;
      r.in_bucket = (64'(win_shift) >= lo) && (64'(win_shift) <= lo + BUCKET_WIDTH - 1);
      if (cfg_sel == 0) begin
        bucket = 64'(win_shift) / BUCKET_WIDTH;
        if (bucket < HIST_BINS && bin_counts[bucket[HIST_AW-1:0]] != '1)
          bin_counts[bucket[HIST_AW-1:0]] = bin_counts[bucket[HIST_AW-1:0]] + 1;
      end
    end
    r.bad_base = seq_error;
    return r;
  endfunction

  function automatic base_word_t make_push(input logic [CHAR_W-1:0] ch, input logic ns);
    base_word_t w;
    w.mode         = MODE_PUSH;
    w.base_char    = ch;
    w.new_sequence = ns;
    w.bin_index    = BIN_W'($urandom);
    return w;
  endfunction

  function automatic base_word_t make_read(input logic [BIN_W-1:0] idx, input logic ns);
    base_word_t w;
    w.mode         = MODE_READ;
    w.base_char    = CHAR_W'($urandom);
    w.new_sequence = ns;
    w.bin_index    = idx;
    return w;
  endfunction

  // Offer one word after a random gap and record its expected result once taken
  task automatic send_word(input base_word_t w);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.mode         = w.mode;
    in_ch.base_char    = w.base_char;
    in_ch.new_sequence = w.new_sequence;
    in_ch.bin_index    = w.bin_index;
    in_ch.valid        = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    kmer_results_q = {kmer_results_q, roll_kmer(w)};
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (kmer_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input kmer_res_t want, input kmer_res_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch %s: expected full=%b kmer=%h start=%h bkt=%b bad=%b cnt=%h",
               what, want.window_full, want.kmer_value, want.window_start, want.in_bucket,
               want.bad_base, want.bin_count, "\n         actual   full=%b kmer=%h start=%h ",
               got.window_full, got.kmer_value, got.window_start,
               "bkt=%b bad=%b cnt=%h", got.in_bucket, got.bad_base, got.bin_count);
  endtask

  // Read a register back and compare with the predicted copy
  task automatic check_reg(input logic idx);
    logic [APB_DW-1:0] want;
    want = (idx == REG_KMER_LENGTH) ? APB_DW'(cfg_len) : APB_DW'(cfg_sel);
    @(negedge clk_i);
    psel   = 1'b1;
    pwrite = 1'b0;
    paddr  = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("mismatch register %0d: expected %h actual %h", idx, want, prdata);
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_KMER_LENGTH) cfg_len = value[LEN_W-1:0];
    else cfg_sel = value[SEL_W-1:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    check_reg(idx);
  endtask

  // Set a register, keeping random upper bits in the written word
  task automatic set_reg(input logic idx, input logic [SEL_W-1:0] field);
    logic [APB_DW-1:0] value;
    value = $urandom;
    if (idx == REG_KMER_LENGTH) value[LEN_W-1:0] = field[LEN_W-1:0];
    else value[SEL_W-1:0] = field;
    write_reg(idx, value);
  endtask

  // Accept and check result words, stalling at random or on a hold request
  initial begin : result_sink
    int unsigned stall;
    kmer_res_t   got;
    kmer_res_t   want;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = stalls_on ? $urandom_range(0, 13) : 0;
        if (stall != 0) begin
          out_ch.ready = 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      got.window_full  = out_ch.window_full;
      got.kmer_value   = out_ch.kmer_value;
      got.window_start = out_ch.window_start;
      got.in_bucket    = out_ch.in_bucket;
      got.bad_base     = out_ch.bad_base;
      got.bin_count    = out_ch.bin_count;
      if (kmer_results_q.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = kmer_results_q.pop_front();
        if (got !== want) note_mismatch("result word", want, got);
      end
    end
  end

  // Abort when no word moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic test_register_reset();
    check_reg(REG_KMER_LENGTH);
    check_reg(REG_BUCKET_SELECT);
  endtask

  // Every base code, N as A, bad characters, sticky error and its clearing
  task automatic test_base_encoding();
    set_reg(REG_KMER_LENGTH, 12'd3);
    send_word(make_push(CHAR_A, 1'b1));
    send_word(make_push(CHAR_C, 1'b0));
    send_word(make_push(CHAR_G, 1'b0));
    send_word(make_push(CHAR_T, 1'b0));
    send_word(make_push(CHAR_N, 1'b0));
    send_word(make_push(LOWER_A, 1'b0));
    send_word(make_push(8'h00, 1'b0));
    send_word(make_push(CHAR_G, 1'b0));
    // new_sequence is ignored on a bin read
    send_word(make_read(12'd0, 1'b1));
    send_word(make_push(CHAR_C, 1'b1));
    send_word(make_push(8'hFF, 1'b0));
    drain_results();
  endtask

  // Length zero acts as one, lengths above the maximum act as the maximum
  task automatic test_length_clamp();
    set_reg(REG_KMER_LENGTH, 12'd0);
    send_word(make_push(CHAR_T, 1'b1));
    send_word(make_push(CHAR_G, 1'b0));
    drain_results();
    set_reg(REG_KMER_LENGTH, 12'd15);
    send_word(make_push(CHAR_T, 1'b1));
    repeat (MAX_KMER_LEN - 1) send_word(make_push(CHAR_T, 1'b0));
    send_word(make_read(12'hFFF, 1'b0));
    drain_results();
  endtask

  // All-T window is the last value of the top bucket; counting stops off bucket zero
  task automatic test_bucket_edge();
    set_reg(REG_BUCKET_SELECT, 12'hFFF);
    send_word(make_push(CHAR_T, 1'b0));
    send_word(make_read(12'hFFF, 1'b0));
    drain_results();
  endtask

  // Shrink the window mid-sequence: fill saturates and TTTTT ends bucket zero
  task automatic test_length_change();
    set_reg(REG_KMER_LENGTH, 12'd5);
    set_reg(REG_BUCKET_SELECT, 12'd0);
    send_word(make_push(CHAR_T, 1'b0));
    drain_results();
  endtask

  // Hold the output off while words keep coming so the input stalls
  task automatic test_backpressure();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    hold_req  = 1'b1;
    repeat (48) send_word(make_push(CHAR_C, 1'b0));
    drain_results();
  endtask

  task automatic test_random_phase(input logic [LEN_W-1:0] len, input logic [SEL_W-1:0] sel,
                                   input bit gaps, input bit stalls,
                                   input int unsigned t_pct, input int unsigned count);
    base_word_t  w;
    int unsigned pick;
    drain_results();
    set_reg(REG_KMER_LENGTH, SEL_W'(len));
    set_reg(REG_BUCKET_SELECT, sel);
    gaps_on   = gaps;
    stalls_on = stalls;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        // read a random bin or the bucket of the current window
        w = make_read(($urandom_range(0, 1) == 0) ? BIN_W'($urandom)
                                                  : win_shift[KMER_W-1:BUCKET_SHIFT],
                      1'(($urandom)));
      end else if (pick < 10) begin
        w = make_push(CHAR_W'($urandom), ($urandom_range(0, 9) == 0));
      end else begin
        if ($urandom_range(0, 99) < t_pct) w = make_push(CHAR_T, 1'b0);
        else begin
          case ($urandom_range(0, 3))
            0:       w = make_push(CHAR_A, 1'b0);
            1:       w = make_push(CHAR_C, 1'b0);
            2:       w = make_push(CHAR_G, 1'b0);
            default: w = make_push(CHAR_N, 1'b0);
          endcase
        end
        w.new_sequence = ($urandom_range(0, 39) == 0);
      end
      send_word(w);
    end
  endtask

  initial begin : run
    foreach (bin_counts[i]) bin_counts[i] = '0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_PUSH;
    in_ch.base_char    = '0;
    in_ch.new_sequence = 1'b0;
    in_ch.bin_index    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_reset();
    test_base_encoding();
    test_length_clamp();
    test_bucket_edge();
    test_length_change();
    test_backpressure();
    test_random_phase(4'd8, 12'd0, 1'b1, 1'b1, 20, 250);
    test_random_phase(4'd1, 12'd0, 1'b0, 1'b0, 20, 200);
    test_random_phase(4'd11, 12'd0, 1'b1, 1'b0, 20, 250);
    test_random_phase(4'd0, 12'd0, 1'b0, 1'b1, 20, 150);
    test_random_phase(4'd15, 12'hFFF, 1'b1, 1'b1, 75, 250);
    test_random_phase(4'd6, 12'd2, 1'b1, 1'b1, 20, 250);
    test_random_phase(4'd4, 12'd0, 1'b1, 1'b1, 20, 200);
    test_random_phase(4'd11, SEL_W'($urandom_range(1, 4094)), 1'b0, 1'b0, 20, 250);
    drain_results();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
